FILE: design/gpp_pkg.sv
// ----------------------------------------------------------------------------
// gpp_pkg
// types, constants and the hat decode shared by the gamepad packet parser
// ----------------------------------------------------------------------------
package gpp_pkg;

	localparam int unsigned PosWidth = 4;
	localparam int unsigned HeldDepth = 7;

	typedef logic [7:0] pkt_byte_t;
	typedef logic [PosWidth-1:0] pos_t;
	typedef logic [2:0] held_idx_t;
	typedef pkt_byte_t [HeldDepth-1:0] held_t;

	localparam pkt_byte_t Header = 8'hAB;
	localparam pkt_byte_t HatMax = 8'd8;

	// packet byte positions
	localparam pos_t PosHeader = 4'd0;
	localparam pos_t PosHat = 4'd3;
	localparam pos_t PosLastHeld = 4'd7;
	localparam pos_t PosLast = 4'd10;

	localparam logic StatusReport = 1'b0;
	localparam logic StatusReject = 1'b1;

	typedef struct packed {
		logic [8:0] buttons;
		logic [3:0] dpad;
		pkt_byte_t  main_x;
		pkt_byte_t  main_y;
		pkt_byte_t  cstick_x;
		pkt_byte_t  cstick_y;
	} report_t;

	function automatic logic [3:0] hat_to_dpad(input pkt_byte_t hat);
		logic [3:0] d;
		case (hat)
			8'd0: d = 4'h1;
			8'd1: d = 4'h3;
			8'd2: d = 4'h2;
			8'd3: d = 4'h6;
			8'd4: d = 4'h4;
			8'd5: d = 4'hC;
			8'd6: d = 4'h8;
			8'd7: d = 4'h9;
			default: d = 4'h0;
		endcase
		return d;
	endfunction

endpackage

FILE: design/gpp_report.sv
// ----------------------------------------------------------------------------
// gpp_report
// builds the report fields from the held packet bytes
// ----------------------------------------------------------------------------
module gpp_report
	import gpp_pkg::*;
(
	input  held_t   held,
	output report_t report
);

	pkt_byte_t b0;
	pkt_byte_t b1;

	assign b0 = held[0];
	assign b1 = held[1];

	always_comb begin
		report.buttons  = {b1[4], b1[1], b1[7], b0[5:0]};
		report.dpad     = hat_to_dpad(held[2]);
		report.main_x   = held[3];
		report.main_y   = ~held[4];
		report.cstick_x = held[5];
		report.cstick_y = ~held[6];
	end

endmodule

FILE: design/gamepad_packet_parser_top.sv
// ----------------------------------------------------------------------------
// gamepad_packet_parser_top
// frames 11-byte serial gamepad packets and emits one report or reject item
// ----------------------------------------------------------------------------
//  channel | signals                      | direction
//  in      | in_valid in_ready rx_byte    | byte stream in
//  out     | out_valid out_ready status   | report or reject out
//          | buttons dpad main_x main_y   |
//          | cstick_x cstick_y            |
//
//  one byte per cycle while no result waits on a full result register; a byte
//  reaches the result register through the input register, then framing logic
//  the result register holds an item until taken; bytes that give no
//  result keep flowing while it waits
//  reset clears the byte position (waiting for header) and all valid flags
// ----------------------------------------------------------------------------
module gamepad_packet_parser_top
	import gpp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       status,
	output logic [8:0] buttons,
	output logic [3:0] dpad,
	output logic [7:0] main_x,
	output logic [7:0] main_y,
	output logic [7:0] cstick_x,
	output logic [7:0] cstick_y
);

	logic      valid_s1;
	pkt_byte_t byte_s1;
	pos_t      position_q;
	held_t     held_q;
	logic      out_valid_q;
	logic      status_q;
	report_t   report_q;

	report_t   report;
	logic      has_result;
	logic      result_status;
	logic      go;
	logic      out_free;
	logic      hold_wr;
	held_idx_t held_idx;
	pos_t      position_d;

	gpp_report u_report (
		.held   (held_q),
		.report (report)
	);

	// framing decision for the byte in the input register
	always_comb begin
		has_result    = 1'b0;
		result_status = StatusReport;
		hold_wr       = 1'b0;
		position_d    = position_q + 4'd1;
		if (position_q == PosHeader) begin
			if (byte_s1 != Header) begin
				has_result    = 1'b1;
				result_status = StatusReject;
				position_d    = PosHeader;
			end
		end else if (position_q > PosLast) begin
			position_d = PosHeader;
		end else if (position_q == PosHat && byte_s1 > HatMax) begin
			has_result    = 1'b1;
			result_status = StatusReject;
			position_d    = PosHeader;
		end else begin
			hold_wr = position_q <= PosLastHeld;
			if (position_q == PosLast) begin
				has_result = 1'b1;
				position_d = PosHeader;
			end
		end
	end

	assign held_idx = held_idx_t'(position_q - 4'd1);
	assign out_free = !out_valid_q || out_ready;
	assign go       = valid_s1 && (!has_result || out_free);
	assign in_ready = !valid_s1 || go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			position_q  <= PosHeader;
			out_valid_q <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (go) begin
				position_q <= position_d;
			end
			if (go && has_result) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= rx_byte;
		end
		if (go && hold_wr) begin
			held_q[held_idx] <= byte_s1;
		end
		if (go && has_result) begin
			status_q <= result_status;
			if (result_status == StatusReject) begin
				report_q <= '0;
			end else begin
				report_q <= report;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign buttons   = report_q.buttons;
	assign dpad      = report_q.dpad;
	assign main_x    = report_q.main_x;
	assign main_y    = report_q.main_y;
	assign cstick_x  = report_q.cstick_x;
	assign cstick_y  = report_q.cstick_y;

`ifndef SYNTHESIS
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		position_q <= PosLast)
		else $error("byte position out of range");

	a_header_reject: assert property (@(posedge clk) disable iff (!arst_n)
		go && position_q == PosHeader && byte_s1 != Header |=>
		position_q == PosHeader && out_valid_q && status_q == StatusReject)
		else $error("bad header not rejected");

	a_result_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		go && has_result |=> position_q == PosHeader)
		else $error("position not back at header after result");

	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && status_q == StatusReject |-> report_q == '0)
		else $error("reject item carries nonzero fields");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |=> out_valid_q && $stable(report_q))
		else $error("pending result lost");
`endif

endmodule

FILE: tb/tb_gamepad_packet_parser_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_gamepad_packet_parser_top
// drives serial packet bytes into the gamepad packet parser, predicts every
// report and reject item from its own framing state and checks each field of
// the output stream in order, under random and long back-pressure
// ----------------------------------------------------------------------------
module tb_gamepad_packet_parser_top;
	import gpp_pkg::*;

	localparam int unsigned HoldCycles = 300;
	localparam int unsigned IdleLimit = 3000;
	localparam int unsigned ItemsPerPhase = 470;
	localparam int unsigned DrainCycles = 8;
	// d-pad bits by hat code, hat 0 in the low nibble
	localparam logic [35:0] DpadByHat = {4'h0, 4'h9, 4'h8, 4'hC, 4'h4, 4'h6, 4'h2, 4'h3, 4'h1};

	typedef struct packed {
		logic    status;
		report_t rep;
	} frame_result_t;

	logic       clk;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [7:0] rx_byte = 8'h00;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic       status;
	logic [8:0] buttons;
	logic [3:0] dpad;
	logic [7:0] main_x;
	logic [7:0] main_y;
	logic [7:0] cstick_x;
	logic [7:0] cstick_y;

	pkt_byte_t     byte_q[$];
	frame_result_t report_q[$];

	pos_t  pkt_pos = PosHeader;
	held_t pkt_held = '0;

	int unsigned send_idle_pct = 27;
	int unsigned recv_idle_pct = 60;
	int unsigned mismatches = 0;
	int unsigned idle_cycles = 0;
	int unsigned stall_token = 0;

	gamepad_packet_parser_top i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.rx_byte  (rx_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status   (status),
		.buttons  (buttons),
		.dpad     (dpad),
		.main_x   (main_x),
		.main_y   (main_y),
		.cstick_x (cstick_x),
		.cstick_y (cstick_y)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic void frame_byte(input pkt_byte_t b);
		frame_result_t r;
		pkt_byte_t     b1;
		pkt_byte_t     hat;
		r = '0;
		if (pkt_pos == PosHeader) begin
			if (b == Header) begin
				pkt_pos = pkt_pos + 4'd1;
			end else begin
				r.status = StatusReject;
				report_q.push_back(r);
			end
		end else if (pkt_pos > PosLast) begin
			pkt_pos = PosHeader;
		end else if (pkt_pos == PosHat && b > HatMax) begin
			pkt_pos = PosHeader;
			r.status = StatusReject;
			report_q.push_back(r);
		end else begin
			if (pkt_pos <= PosLastHeld)
				pkt_held[pkt_pos - 4'd1] = b;
			if (pkt_pos == PosLast) begin
				pkt_pos = PosHeader;
				b1 = pkt_held[1];
				hat = pkt_held[2];
				r.status = StatusReport;
				r.rep.buttons = {b1[4], b1[1], b1[7], pkt_held[0][5:0]};
				r.rep.dpad = (hat <= HatMax) ? DpadByHat[hat * 4 +: 4] : 4'h0;
				r.rep.main_x = pkt_held[3];
				r.rep.main_y = 8'd255 - pkt_held[4];
				r.rep.cstick_x = pkt_held[5];
				r.rep.cstick_y = 8'd255 - pkt_held[6];
				report_q.push_back(r);
			end else begin
				pkt_pos = pkt_pos + 4'd1;
			end
		end
	endfunction

	task automatic check_field(input string fname, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
			mismatches++;
		end
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin : drive_proc
		logic took;
		if (!arst_n) begin
			in_valid <= 1'b0;
			rx_byte <= 8'h00;
		end else begin
			took = in_valid && in_ready;
			if (took)
				frame_byte(rx_byte);
			if (!in_valid || took) begin
				if (byte_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					rx_byte <= byte_q.pop_front();
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin : monitor_proc
		frame_result_t want;
		int unsigned   hold_left;
		int unsigned   stall_seen;
		if (!arst_n) begin
			out_ready <= 1'b0;
			hold_left = 0;
			stall_seen = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (report_q.size() == 0) begin
					$display("%0t: unexpected item, expected none, actual status %0d", $time,
						status);
					mismatches++;
				end else begin
					want = report_q.pop_front();
					check_field("status", want.status, status);
					check_field("buttons", want.rep.buttons, buttons);
					check_field("dpad", want.rep.dpad, dpad);
					check_field("main_x", want.rep.main_x, main_x);
					check_field("main_y", want.rep.main_y, main_y);
					check_field("cstick_x", want.rep.cstick_x, cstick_x);
					check_field("cstick_y", want.rep.cstick_y, cstick_y);
				end
			end
			if (stall_seen != stall_token) begin
				stall_seen = stall_token;
				hold_left = HoldCycles;
			end
			if (hold_left != 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IdleLimit) begin
			$display("%0t: no progress for %0d cycles", $time, idle_cycles);
			$display("Test completed with failures");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// fill < 0 gives random bytes after the header, the hat byte apart
	task automatic push_packet(input pkt_byte_t hat, input int fill);
		int unsigned k;
		byte_q.push_back(Header);
		for (k = 0; k < 2; k++)
			byte_q.push_back(fill < 0 ? pkt_byte_t'($urandom_range(255)) : pkt_byte_t'(fill));
		byte_q.push_back(hat);
		if (hat <= HatMax) begin
			for (k = 0; k < 7; k++)
				byte_q.push_back(fill < 0 ? pkt_byte_t'($urandom_range(255)) :
					pkt_byte_t'(fill));
		end
	endtask

	task automatic push_random(input int unsigned count);
		int unsigned target;
		int unsigned pick;
		target = byte_q.size() + count;
		while (byte_q.size() < target) begin
			pick = $urandom_range(99);
			if (pick < 75)
				push_packet(pkt_byte_t'($urandom_range(8)), -1);
			else if (pick < 85)
				push_packet(pkt_byte_t'($urandom_range(255, 9)), -1);
			else if (pick < 90)
				byte_q.push_back(Header);
			else
				byte_q.push_back(pkt_byte_t'($urandom_range(255)));
		end
	endtask

	task automatic wait_idle();
		while (byte_q.size() != 0 || in_valid || report_q.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// wrong header, bad hat, all-zero packet, all-ones packet with no hat, hat one past the limit
		byte_q.push_back(8'h00);
		push_packet(8'hFF, 255);
		push_packet(8'h00, 0);
		push_packet(HatMax, 255);
		push_packet(HatMax + 8'd1, 0);

		push_random(ItemsPerPhase / 2);
		wait_idle();
		push_random(ItemsPerPhase / 2);
		while (byte_q.size() != 0)
			@(posedge clk);

		send_idle_pct = 60;
		recv_idle_pct = 27;
		push_random(ItemsPerPhase);
		while (byte_q.size() != 0)
			@(posedge clk);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		push_random(ItemsPerPhase);
		stall_token++;
		wait_idle();
		repeat (DrainCycles) @(posedge clk);

		if (mismatches == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
